// ----- hw/rtl/string_intern_table_macros.svh -----
// Assertion macros for the intern table checker
`ifndef STRING_INTERN_TABLE_MACROS_SVH
`define STRING_INTERN_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SIT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define SIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/sit_pkg.sv -----
package sit_pkg;

  localparam int MaxEntries = 128;
  localparam int PoolBytes  = 4096;
  localparam int MaxNameLen = 255;

  localparam int EntW = $clog2(MaxEntries);
  localparam int PoolW = $clog2(PoolBytes);
  localparam int PendW = $clog2(MaxNameLen + 1);
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int TopW = $clog2(PoolBytes + 1);

  typedef enum logic [1:0] {
    OP_INTERN = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_ADDED      = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_POOL_FULL  = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_BAD_INDEX  = 3'd5,
    ST_TOO_LONG   = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] name_byte;
    logic       byte_present;
    logic       last;
    logic [6:0] entry_index;
    logic [7:0] position;
  } in_word_t;

  typedef struct packed {
    logic [6:0] result_index;
    logic [2:0] status;
    logic [7:0] read_byte;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FINISH,
    S_ENT_RD,
    S_LEN_RD,
    S_LEN_CHK,
    S_BYTE_RD,
    S_BYTE_CHK,
    S_APPEND,
    S_WR_NUL,
    S_RD_OFF,
    S_RD_LEN,
    S_RD_BYTE,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     take;       // register input word, buffer byte
    logic     pend_clr;   // empty pending buffer
    logic     clear_all;  // empty table
    logic     ent_rd;     // read offset of scan entry
    logic     len_rd;     // read pool at offset
    logic     byte_rd;    // read pool byte k, pending byte k
    logic     k_inc;
    logic     k_clr;
    logic     i_inc;
    logic     i_clr;
    logic     app_wr;     // write length or byte k-1 at top + k
    logic     nul_wr;     // write NUL, commit entry
    logic     rd_off;     // read offset of entry_index
    logic     rd_len;
    logic     rd_byte;
    logic     set_res;
    status_t  res_status;
    logic     res_from_i;
    logic     res_rd_idx;
    logic     out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic     is_last;
    logic     op_intern;
    logic     op_read;
    logic     op_clear;
    logic     overflow;
    logic     scan_done;  // i >= entry_count
    logic     len_eq;
    logic     k_done;     // k == pending length
    logic     byte_eq;
    logic     table_full;
    logic     pool_full;
    logic     app_done;   // k > pending length
    logic     bad_index;
    logic     pos_in;     // position < stored length
  } sts_t;

endpackage

// ----- hw/rtl/sit_datapath.sv -----
module sit_datapath
  import sit_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t res
);

  // Storage
  logic [PoolW-1:0] offsets [MaxEntries];
  logic [7:0]       pool [PoolBytes];
  logic [7:0]       pend [MaxNameLen];

  logic [CntW-1:0]  entry_count;
  logic [TopW-1:0]  pool_top;
  logic [PendW-1:0] pend_len;
  logic             overflow;
  in_word_t         cur;
  logic [CntW-1:0]  i;
  logic [PendW:0]   k;
  logic [PoolW-1:0] off;
  logic [7:0]       pool_q;
  logic [7:0]       pend_q;
  logic [7:0]       stored_len;

  logic [PoolW-1:0] pool_addr;
  logic             pool_we;
  logic [7:0]       pool_wd;
  logic [TopW+1:0]  need;
  logic [PendW-1:0] kp;

  assign kp = k[PendW-1:0];
  assign need = {2'b0, pool_top} + {{(TopW+2-PendW){1'b0}}, pend_len} + (TopW+2)'(2);

  // Pool address select
  always_comb begin
    pool_we = 1'b0;
    pool_wd = 8'd0;
    pool_addr = off;
    if (cmd.len_rd) begin
      pool_addr = off;
    end else if (cmd.byte_rd) begin
      pool_addr = PoolW'(off + PoolW'(k) + PoolW'(1));
    end else if (cmd.app_wr) begin
      pool_addr = PoolW'(pool_top + TopW'(k));
      pool_we = 1'b1;
      pool_wd = (k == '0) ? 8'(pend_len) : pend_q;
    end else if (cmd.nul_wr) begin
      pool_addr = PoolW'(pool_top + TopW'(k));
      pool_we = 1'b1;
    end else if (cmd.rd_len) begin
      pool_addr = off;
    end else if (cmd.rd_byte) begin
      pool_addr = PoolW'(off + PoolW'(cur.position) + PoolW'(1));
    end
  end

  // Pool memory
  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool[pool_addr] <= pool_wd;
    end
    pool_q <= pool[pool_addr];
  end

  // Pending buffer: byte k-1 prefetched for append, byte k for compare
  always_ff @(posedge clk) begin
    if (cmd.take && in_word.opcode == OP_INTERN && in_word.byte_present &&
        pend_len < PendW'(MaxNameLen)) begin
      pend[pend_len] <= in_word.name_byte;
    end
    if (cmd.app_wr) begin
      pend_q <= (kp < PendW'(MaxNameLen)) ? pend[kp] : 8'd0;
    end else begin
      pend_q <= (kp < PendW'(MaxNameLen)) ? pend[kp] : 8'd0;
    end
  end

  // Offsets memory
  always_ff @(posedge clk) begin
    if (cmd.nul_wr) begin
      offsets[i[EntW-1:0]] <= PoolW'(pool_top);
    end
    if (cmd.ent_rd) begin
      off <= offsets[i[EntW-1:0]];
    end else if (cmd.rd_off) begin
      off <= offsets[cur.entry_index[EntW-1:0]];
    end
    // pool_q holds the length byte while the data byte is fetched
    if (cmd.rd_byte) begin
      stored_len <= pool_q;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      entry_count <= '0;
      pool_top <= '0;
      pend_len <= '0;
      overflow <= 1'b0;
    end else begin
      if (cmd.take && in_word.opcode == OP_INTERN && in_word.byte_present) begin
        if (pend_len < PendW'(MaxNameLen)) begin
          pend_len <= pend_len + PendW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.pend_clr) begin
        pend_len <= '0;
        overflow <= 1'b0;
      end
      if (cmd.nul_wr) begin
        entry_count <= entry_count + CntW'(1);
        pool_top <= TopW'(pool_top + TopW'(k) + TopW'(1));
      end
    end
  end

  // Scan counters and input word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur <= in_word;
    end
    if (cmd.i_clr) begin
      i <= '0;
    end else if (cmd.i_inc) begin
      i <= i + CntW'(1);
    end
    if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + (PendW+1)'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res.status <= cmd.res_status;
      res.read_byte <= 8'd0;
      if (cmd.res_from_i) begin
        res.result_index <= 7'(i);
      end else if (cmd.res_rd_idx) begin
        res.result_index <= cur.entry_index;
      end else begin
        res.result_index <= 7'd0;
      end
    end
    if (cmd.out_load) begin
      res.read_byte <= sts.pos_in ? pool_q : 8'd0;
    end
  end

  // Status
  assign sts.is_last = cur.last;
  assign sts.op_intern = cur.opcode == OP_INTERN;
  assign sts.op_read = cur.opcode == OP_READ;
  assign sts.op_clear = cur.opcode == OP_CLEAR;
  assign sts.overflow = overflow;
  assign sts.scan_done = i >= entry_count;
  assign sts.len_eq = pool_q == 8'(pend_len);
  assign sts.k_done = k == {1'b0, pend_len};
  assign sts.byte_eq = pool_q == pend_q;
  assign sts.table_full = entry_count >= CntW'(MaxEntries);
  assign sts.pool_full = need > (TopW+2)'(PoolBytes);
  assign sts.app_done = k > {1'b0, pend_len};
  assign sts.bad_index = {1'b0, cur.entry_index} >= 8'(entry_count) ||
                         {1'b0, cur.entry_index} >= 8'(MaxEntries);
  assign sts.pos_in = cur.position < stored_len;

endmodule

// ----- hw/rtl/sit_ctrl.sv -----
module sit_ctrl
  import sit_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   busy;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && !out_valid) state_next = S_FINISH;
      S_FINISH: begin
        if (sts.op_intern && sts.is_last) begin
          state_next = sts.overflow ? S_OUT : S_ENT_RD;
        end else if (sts.op_read) begin
          state_next = sts.bad_index ? S_OUT : S_RD_OFF;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ENT_RD: begin
        if (sts.scan_done) begin
          state_next = (sts.table_full || sts.pool_full) ? S_OUT : S_APPEND;
        end else begin
          state_next = S_LEN_RD;
        end
      end
      S_LEN_RD: state_next = S_LEN_CHK;
      S_LEN_CHK: begin
        if (!sts.len_eq) state_next = S_ENT_RD;
        else if (sts.k_done) state_next = S_OUT;
        else state_next = S_BYTE_RD;
      end
      S_BYTE_RD: state_next = S_BYTE_CHK;
      S_BYTE_CHK: begin
        if (!sts.byte_eq) state_next = S_ENT_RD;
        else if (sts.k_done) state_next = S_OUT;
        else state_next = S_BYTE_RD;
      end
      S_APPEND: if (sts.app_done) state_next = S_WR_NUL;
      S_WR_NUL: state_next = S_OUT;
      S_RD_OFF: state_next = S_RD_LEN;
      S_RD_LEN: state_next = S_RD_BYTE;
      S_RD_BYTE: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign busy = state != S_IDLE;
  assign in_ready = !busy && !out_valid;

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.res_status = ST_FOUND;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid && !out_valid;
        cmd.i_clr = 1'b1;
        cmd.k_clr = 1'b1;
      end
      S_FINISH: begin
        if (sts.op_clear) cmd.clear_all = 1'b1;
        if (sts.op_intern && sts.is_last && sts.overflow) begin
          cmd.set_res = 1'b1;
          cmd.res_status = ST_TOO_LONG;
          cmd.pend_clr = 1'b1;
        end
        if (sts.op_read) begin
          cmd.set_res = 1'b1;
          cmd.res_rd_idx = 1'b1;
          cmd.res_status = sts.bad_index ? ST_BAD_INDEX : ST_READ_OK;
        end
      end
      S_ENT_RD: begin
        cmd.k_clr = 1'b1;
        if (sts.scan_done) begin
          if (sts.table_full) begin
            cmd.set_res = 1'b1;
            cmd.res_status = ST_TABLE_FULL;
            cmd.pend_clr = 1'b1;
          end else if (sts.pool_full) begin
            cmd.set_res = 1'b1;
            cmd.res_status = ST_POOL_FULL;
            cmd.pend_clr = 1'b1;
          end
        end else begin
          cmd.ent_rd = 1'b1;
        end
      end
      S_LEN_RD: cmd.len_rd = 1'b1;
      S_LEN_CHK: begin
        // pool_q holds the stored length
        if (!sts.len_eq) begin
          cmd.i_inc = 1'b1;
        end else if (sts.k_done) begin
          cmd.set_res = 1'b1;
          cmd.res_from_i = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.pend_clr = 1'b1;
        end
      end
      S_BYTE_RD: begin
        cmd.byte_rd = 1'b1;
        cmd.k_inc = 1'b1;
      end
      S_BYTE_CHK: begin
        // stage holds pool byte k-1 and pending byte k-1
        if (!sts.byte_eq) begin
          cmd.i_inc = 1'b1;
        end else if (sts.k_done) begin
          cmd.set_res = 1'b1;
          cmd.res_from_i = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.pend_clr = 1'b1;
        end
      end
      S_APPEND: begin
        cmd.app_wr = !sts.app_done;
        cmd.k_inc = !sts.app_done;
      end
      S_WR_NUL: begin
        cmd.nul_wr = 1'b1;
        cmd.set_res = 1'b1;
        cmd.res_from_i = 1'b1;
        cmd.res_status = ST_ADDED;
        cmd.pend_clr = 1'b1;
      end
      S_RD_OFF: cmd.rd_off = 1'b1;
      S_RD_LEN: cmd.rd_len = 1'b1;
      S_RD_BYTE: cmd.rd_byte = 1'b1;
      S_OUT: cmd.out_load = sts.op_read && !sts.bad_index;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/string_intern_table.sv -----
// Channel | Dir | Payload    | Handshake
// in      | in  | in_word_t  | in_valid / in_ready
// out     | out | out_word_t | out_valid / out_ready
//
// A byte item is taken, then finished. A finished name is compared with
// each stored entry, length then bytes; with no match and room left, its
// length, bytes and NUL are appended; reads fetch offset, length, byte.
// Reset is synchronous; the pool and offset stores hold no reset value.
// A held result blocks the next item until it is taken.
module string_intern_table
  import sit_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  cmd_t cmd;
  sts_t sts;

  sit_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  sit_datapath u_dp (
    .clk(clk), .rst(rst), .in_word(in_word), .cmd(cmd), .sts(sts), .res(out_word)
  );

endmodule

// ----- hw/rtl/sit_checker.sv -----
`include "string_intern_table_macros.svh"
module sit_checker
  import sit_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // A held result never gets dropped
  `SIT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // Status code is in range
  `SIT_ASSERT_IMP(a_status_ok, clk, rst, out_valid, out_word.status != 3'd7)
  // Results other than a successful read carry no byte
  `SIT_ASSERT_IMP(a_byte_zero, clk, rst,
    out_valid && out_word.status != ST_READ_OK, out_word.read_byte == 8'd0)
  // No input taken while a result waits
  `SIT_ASSERT_IMP(a_no_take, clk, rst, out_valid, !in_ready)

endmodule

bind string_intern_table sit_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);

// ----- tb/sv/sit_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the intern table, predicts each result word and
// compares it with what the block returns.
module sit_scoreboard
  import sit_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending_results
);

  // Shadow copy of the table
  int unsigned name_count;
  int unsigned pool_fill;
  int unsigned name_offset [MaxEntries];
  logic [7:0]  pool_mem [PoolBytes];
  logic [7:0]  partial_name [MaxNameLen];
  int unsigned partial_len;
  logic        partial_over;

  out_word_t expected_words [$];

  assign pending_results = expected_words.size();

  function automatic out_word_t make_word(int unsigned idx, status_t st, logic [7:0] b);
    out_word_t w;
    w.result_index = idx[6:0];
    w.status       = st;
    w.read_byte    = b;
    return w;
  endfunction

  // Lookup or append of the finished name
  function automatic out_word_t close_name();
    int unsigned n;
    int unsigned off;
    logic        over;
    logic        hit;
    n            = partial_len;
    over         = partial_over;
    partial_len  = 0;
    partial_over = 1'b0;
    if (over) return make_word(0, ST_TOO_LONG, 8'd0);
    for (int unsigned i = 0; i < name_count; i++) begin
      off = name_offset[i];
      hit = (pool_mem[off] == n[7:0]);
      for (int unsigned k = 0; hit && k < n; k++)
        if (pool_mem[off + 1 + k] != partial_name[k]) hit = 1'b0;
      if (hit) return make_word(i, ST_FOUND, 8'd0);
    end
    if (name_count >= MaxEntries) return make_word(0, ST_TABLE_FULL, 8'd0);
    if (pool_fill + n + 2 > PoolBytes) return make_word(0, ST_POOL_FULL, 8'd0);
    name_offset[name_count] = pool_fill;
    pool_mem[pool_fill] = n[7:0];
    for (int unsigned k = 0; k < n; k++) pool_mem[pool_fill + 1 + k] = partial_name[k];
    pool_mem[pool_fill + 1 + n] = 8'd0;
    pool_fill += n + 2;
    name_count++;
    return make_word(name_count - 1, ST_ADDED, 8'd0);
  endfunction

  // Advance the shadow on each accepted input word
  task automatic apply_word(in_word_t w);
    int unsigned off;
    logic [7:0]  b;
    case (op_t'(w.opcode))
      OP_INTERN: begin
        if (w.byte_present) begin
          if (partial_len < MaxNameLen) begin
            partial_name[partial_len] = w.name_byte;
            partial_len++;
          end else begin
            partial_over = 1'b1;
          end
        end
        if (w.last) expected_words.push_back(close_name());
      end
      OP_READ: begin
        if (w.entry_index >= name_count) begin
          expected_words.push_back(make_word(w.entry_index, ST_BAD_INDEX, 8'd0));
        end else begin
          off = name_offset[w.entry_index];
          b = (w.position < pool_mem[off]) ? pool_mem[off + 1 + w.position] : 8'd0;
          expected_words.push_back(make_word(w.entry_index, ST_READ_OK, b));
        end
      end
      OP_CLEAR: begin
        name_count   = 0;
        pool_fill    = 0;
        partial_len  = 0;
        partial_over = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      name_count   = 0;
      pool_fill    = 0;
      partial_len  = 0;
      partial_over = 1'b0;
      fail_count   <= 0;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) apply_word(in_word);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: idx %0d st %0d byte %0h",
                     out_word.result_index, out_word.status, out_word.read_byte);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w !== out_word) begin
            if (fail_count < 10)
              $display("mismatch: exp idx %0d st %0d byte %0h, got idx %0d st %0d byte %0h",
                       exp_w.result_index, exp_w.status, exp_w.read_byte,
                       out_word.result_index, out_word.status, out_word.read_byte);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import sit_pkg::*;

  localparam int StallLimit = 200000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  int        fail_count;
  int        pending_results;
  int        idle_cycles;
  logic      calm_phase;
  logic      hold_off;

  string_intern_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  sit_scoreboard u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, a long hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= calm_phase || ($urandom_range(99) >= 8);
    end
  end

  initial begin
    hold_off = 1'b0;
    @(negedge rst);
    repeat (200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog on cycles without any accepted word
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one word, sometimes with a random gap first, and wait for acceptance
  task automatic send_word(op_t op, logic [7:0] b, logic pres, logic lst,
                           logic [6:0] idx, logic [7:0] pos);
    in_word_t w;
    w.opcode = op;
    w.name_byte = b;
    w.byte_present = pres;
    w.last = lst;
    w.entry_index = idx;
    w.position = pos;
    if (!calm_phase && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_name(int unsigned len, logic [7:0] seed_b, logic varied);
    for (int unsigned k = 0; k < len; k++)
      send_word(OP_INTERN, varied ? 8'($urandom) : seed_b + k[7:0], 1'b1,
                k == len - 1, 7'($urandom), 8'($urandom));
    if (len == 0) send_word(OP_INTERN, 8'($urandom), 1'b0, 1'b1, 7'd0, 8'd0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  initial begin
    int unsigned items;
    int unsigned len;
    int unsigned r;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    calm_phase = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty name, repeats, extremes, reads, too long, odd opcode, clear
    send_name(0, 8'd0, 1'b0);
    send_name(0, 8'd0, 1'b0);
    send_word(OP_INTERN, 8'hFF, 1'b1, 1'b0, 7'h7F, 8'hFF);
    send_word(OP_INTERN, 8'h00, 1'b1, 1'b0, 7'h00, 8'h00);
    send_word(OP_INTERN, 8'h55, 1'b0, 1'b1, 7'h7F, 8'hFF);
    send_word(OP_INTERN, 8'hFF, 1'b1, 1'b1, 7'h00, 8'h00);
    send_word(OP_READ, 8'hFF, 1'b1, 1'b1, 7'd1, 8'd0);
    send_word(OP_READ, 8'h00, 1'b0, 1'b0, 7'd1, 8'd1);
    send_word(OP_READ, 8'h00, 1'b0, 1'b0, 7'd1, 8'd2);
    send_word(OP_READ, 8'h00, 1'b0, 1'b0, 7'd1, 8'hFF);
    send_word(OP_READ, 8'h00, 1'b0, 1'b0, 7'd0, 8'd0);
    send_word(OP_READ, 8'h00, 1'b0, 1'b0, 7'd2, 8'd0);
    send_word(OP_READ, 8'h00, 1'b0, 1'b0, 7'h7F, 8'd0);
    send_word(OP_NONE, 8'hAA, 1'b1, 1'b1, 7'd0, 8'd0);
    send_name(255, 8'd1, 1'b1);
    send_name(256, 8'd1, 1'b1);
    send_word(OP_CLEAR, 8'h00, 1'b1, 1'b1, 7'd0, 8'd0);
    send_word(OP_READ, 8'h00, 1'b0, 1'b0, 7'd0, 8'd0);
    drain();

    // Fill the table with 128 short names, offer one more, then repeat a stored name
    for (int unsigned i = 0; i <= MaxEntries; i++) send_name(1 + i % 3, 8'(i * 7), 1'b0);
    send_name(2, 8'd7, 1'b0);
    drain();
    send_word(OP_CLEAR, 8'h00, 1'b0, 1'b0, 7'd0, 8'd0);

    // Random: mostly short names from a small alphabet so lookups hit, plus reads, clears and odd opcodes
    items = 0;
    while (items < 500) begin
      calm_phase <= (items >= 200 && items < 300);
      r = $urandom_range(99);
      if (r < 55) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4);
        for (int unsigned k = 0; k < len; k++)
          send_word(OP_INTERN, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(65, 67)),
                    1'b1, 1'b0, 7'($urandom), 8'($urandom));
        send_word(OP_INTERN, 8'($urandom_range(65, 66)), 1'($urandom), 1'b1,
                  7'($urandom), 8'($urandom));
        items += len + 1;
      end else if (r < 90) begin
        send_word(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom),
                  7'($urandom_range(u_checker.name_count + 2)), 8'($urandom_range(5)));
        items++;
      end else if (r < 93) begin
        send_word(OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom),
                  7'($urandom), 8'($urandom));
        items++;
      end else if (r < 96) begin
        send_word(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom),
                  7'($urandom), 8'($urandom));
      end else begin
        send_word(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom),
                  7'($urandom), 8'($urandom));
        items++;
      end
    end
    calm_phase <= 1'b0;
    drain();

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/sit_pkg.sv
hw/rtl/sit_datapath.sv
hw/rtl/sit_ctrl.sv
hw/rtl/string_intern_table.sv
hw/rtl/sit_checker.sv
tb/sv/sit_checker.sv
tb/sv/tb_top.sv
